// ===== src/b58dk_pkg.sv =====
`timescale 1ns / 1ps
// Package for the base58 key decoder: sizes, status and state codes, the
// accumulator control bundle and the character-to-digit map. No dependencies.
package b58dk_pkg;

  localparam int KEY_BYTES = 32;
  localparam int MAX_CHARS = 44;

  localparam int ACC_W     = KEY_BYTES * 8;
  localparam int BI_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_CHARS + 2);
  localparam int ZR_W      = $clog2(KEY_BYTES + 1);
  localparam int CMP_W     = (CNT_W > ZR_W) ? CNT_W : ZR_W;
  localparam int WORD_W    = 64;
  localparam int IDX_W     = 2;
  localparam int RAW_WORDS = (KEY_BYTES + 7) / 8;
  localparam int NUM_WORDS = (RAW_WORDS > 4) ? 4 : RAW_WORDS;

  localparam logic [7:0] BASE     = 8'd58;
  localparam logic [7:0] CHAR_ONE = 8'h31;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_LONG     = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LEADING  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FOLD,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fold_en;
    logic shift_word;
    logic clear;
  } acc_ctrl_t;

  // Returns {bad, digit}; bad is set for a byte outside the alphabet.
  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'b1000000;
    if (c >= 8'h31 && c <= 8'h39) r = {1'b0, 6'(c - 8'h31)};
    else if (c >= 8'h41 && c <= 8'h48) r = {1'b0, 6'(c - 8'h41 + 8'd9)};
    else if (c >= 8'h4A && c <= 8'h4E) r = {1'b0, 6'(c - 8'h4A + 8'd17)};
    else if (c >= 8'h50 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h50 + 8'd22)};
    else if (c >= 8'h61 && c <= 8'h6B) r = {1'b0, 6'(c - 8'h61 + 8'd33)};
    else if (c >= 8'h6D && c <= 8'h7A) r = {1'b0, 6'(c - 8'h6D + 8'd44)};
    return r;
  endfunction

endpackage

// ===== src/b58dk_acc.sv =====
`timescale 1ns / 1ps
// Byte-serial big-endian accumulator: multiplies by 58 and adds a digit one
// byte per cycle while step is set, counts leading zero bytes, and shifts out
// 64-bit words. Depends on b58dk_pkg.
module b58dk_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  b58dk_pkg::acc_ctrl_t           ctrl,
  input  logic [5:0]                     digit,
  output logic [5:0]                     carry,
  output logic [b58dk_pkg::ZR_W-1:0]     zero_run,
  output logic [b58dk_pkg::WORD_W-1:0]   top_word
);
  import b58dk_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [5:0]       carry_r, carry_nxt;
  logic [ZR_W-1:0]  zr_r, zr_nxt;
  logic [7:0]       cur_byte, new_byte;
  logic [13:0]      prod;

  assign cur_byte = acc_r[7:0];
  assign prod     = 14'(cur_byte) * 14'(BASE) + 14'(carry_r);
  assign new_byte = ctrl.fold_en ? prod[7:0] : cur_byte;

  always_comb begin
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    zr_nxt    = zr_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.shift_word) begin
      acc_nxt = acc_r << WORD_W;
    end else if (ctrl.step) begin
      acc_nxt = {new_byte, acc_r[ACC_W-1:8]};
      if (ctrl.fold_en) begin
        carry_nxt = prod[13:8];
      end
      zr_nxt = (new_byte == 8'd0) ? zr_r + ZR_W'(1) : '0;
    end
    if (ctrl.load) begin
      carry_nxt = digit;
      zr_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      carry_r <= '0;
      zr_r    <= '0;
    end else begin
      acc_r   <= acc_nxt;
      carry_r <= carry_nxt;
      zr_r    <= zr_nxt;
    end
  end

  assign carry    = carry_r;
  assign zero_run = zr_r;
  assign top_word = acc_r[ACC_W-1 -: WORD_W];

endmodule

// ===== src/base58_decode_key_top.sv =====
`timescale 1ns / 1ps
// Base58 (Bitcoin alphabet) key decoder. Each input beat carries one character;
// it is accepted in S_IDLE, folded in S_FOLD by the byte-serial multiply by 58
// over the accumulator and checked in S_CHECK; in_stall is high outside S_IDLE.
// After the final character the key leaves as four 64-bit beats, most
// significant first, or as one error beat. Depends on b58dk_pkg and b58dk_acc.
module base58_decode_key_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_key_word,
  output logic [1:0]  out_word_index,
  output logic [2:0]  out_status,
  output logic        out_last_word
);
  import b58dk_pkg::*;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, lead_r, lead_nxt;
  logic            prefix_r, prefix_nxt;
  status_t         err_r, err_nxt, status_r, status_nxt;
  logic            fold_r, fold_nxt, last_r, last_nxt;
  logic [BI_W-1:0] bi_r, bi_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [6:0]      dmap;
  logic [5:0]      carry;
  logic [ZR_W-1:0] zero_run;
  logic [WORD_W-1:0] top_word;
  acc_ctrl_t       ctrl;
  logic            in_acc, out_acc, final_word, overflow;

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;
  assign dmap       = digit_of(in_char_code);
  assign final_word = (status_r != ST_OK) || (idx_r == IDX_W'(NUM_WORDS - 1));
  assign overflow   = fold_r && (carry != 6'd0);

  b58dk_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .digit    (dmap[5:0]),
    .carry    (carry),
    .zero_run (zero_run),
    .top_word (top_word)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_FOLD;
      S_FOLD:  if (bi_r == BI_W'(KEY_BYTES - 1)) state_nxt = S_CHECK;
      S_CHECK: state_nxt = last_r ? S_EMIT : S_IDLE;
      S_EMIT:  if (out_acc && final_word) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    lead_nxt   = lead_r;
    prefix_nxt = prefix_r;
    err_nxt    = err_r;
    status_nxt = status_r;
    fold_nxt   = fold_r;
    last_nxt   = last_r;
    bi_nxt     = bi_r;
    idx_nxt    = idx_r;
    ctrl       = '0;
    ctrl.fold_en = fold_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last_char;
          fold_nxt = 1'b0;
          bi_nxt   = '0;
          ctrl.load = 1'b1;
          if (cnt_r <= CNT_W'(MAX_CHARS)) cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_nxt <= CNT_W'(MAX_CHARS) && err_r == ST_OK) begin
            if (prefix_r && in_char_code == CHAR_ONE) begin
              lead_nxt = lead_r + CNT_W'(1);
            end else begin
              prefix_nxt = 1'b0;
              if (dmap[6]) err_nxt = ST_BADCHAR;
              else fold_nxt = 1'b1;
            end
          end
        end
      end
      S_FOLD: begin
        ctrl.step = 1'b1;
        bi_nxt = bi_r + BI_W'(1);
      end
      S_CHECK: begin
        if (overflow) err_nxt = ST_OVERFLOW;
        idx_nxt = '0;
        priority if (cnt_r > CNT_W'(MAX_CHARS)) status_nxt = ST_LONG;
        else if (overflow) status_nxt = ST_OVERFLOW;
        else if (err_r != ST_OK) status_nxt = err_r;
        else if (CMP_W'(zero_run) < CMP_W'(lead_r)) status_nxt = ST_LEADING;
        else status_nxt = ST_OK;
        if (last_r && status_nxt != ST_OK) ctrl.clear = 1'b1;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (final_word) begin
            ctrl.clear = 1'b1;
            cnt_nxt    = '0;
            lead_nxt   = '0;
            prefix_nxt = 1'b1;
            err_nxt    = ST_OK;
          end else begin
            ctrl.shift_word = 1'b1;
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != S_IDLE);
    out_valid      = (state_r == S_EMIT);
    out_key_word   = top_word;
    out_word_index = idx_r;
    out_status     = status_r;
    out_last_word  = final_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      lead_r   <= '0;
      prefix_r <= 1'b1;
      err_r    <= ST_OK;
      status_r <= ST_OK;
      fold_r   <= 1'b0;
      last_r   <= 1'b0;
      bi_r     <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      lead_r   <= lead_nxt;
      prefix_r <= prefix_nxt;
      err_r    <= err_nxt;
      status_r <= status_nxt;
      fold_r   <= fold_nxt;
      last_r   <= last_nxt;
      bi_r     <= bi_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule
